/* rtl/msel_pkg.sv */
// Package for the MET and jet event selector.
// Holds widths, codes, the CORDIC angle table and the controller command types.
// No dependencies.
package msel_pkg;

  localparam int HIST_BINS    = 26;
  localparam int HIST_SETS    = 4;
  localparam int HIST_DEPTH   = HIST_SETS * HIST_BINS;
  localparam int HIST_AW      = $clog2(HIST_DEPTH);
  localparam int BIN_W        = 5;
  localparam int SEL_W        = 2;
  localparam int COUNT_WIDTH  = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_STEPS  = 24;
  localparam int STEP_W       = $clog2(TABLE_STEPS);
  localparam int CW           = 34;
  localparam int ZW           = 32;
  localparam int PT_W         = 20;
  localparam int ANG_W        = 16;
  localparam int BW_W         = 16;
  localparam int DIV_STEPS    = PT_W;
  localparam int DSTEP_W      = $clog2(DIV_STEPS);
  localparam int CFG_W        = 20;
  localparam int CFG_IDX_W    = 3;
  localparam int OUT_W        = 32;
  localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;
  localparam logic [ANG_W-1:0] GAP_RESET = 16'h8000;

  typedef enum logic [2:0] {
    MODE_ELECTRON = 3'd0,
    MODE_MUON     = 3'd1,
    MODE_JET      = 3'd2,
    MODE_MET      = 3'd3,
    MODE_READ     = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEPTON_PT   = 3'd0,
    CFG_JET_GAP_PT  = 3'd1,
    CFG_MET         = 3'd2,
    CFG_LEADING_JET = 3'd3,
    CFG_GAP_ANGLE   = 3'd4,
    CFG_BIN_WIDTH   = 3'd5
  } cfg_index_t;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct packed {
    logic [2:0]        mode;
    logic [PT_W-1:0]   px;
    logic [PT_W-1:0]   py;
    logic [PT_W-1:0]   met_value;
    logic [ANG_W-1:0]  met_angle;
    logic [SEL_W-1:0]  hist_select;
    logic [BIN_W-1:0]  bin_index;
    logic              last_in_event;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic              veto_passed;
    logic [PT_W-1:0]   leading_jet_pt;
    logic [PT_W-1:0]   missing_et;
    logic [ANG_W-1:0]  min_jet_met_gap;
    logic              in_signal_region;
    logic [OUT_W-1:0]  bin_count;
    logic [OUT_W-1:0]  total_count;
    logic [OUT_W-1:0]  veto_count;
    logic [OUT_W-1:0]  gap_count;
    logic [OUT_W-1:0]  veto_gap_count;
  } out_item_t;

  typedef struct packed {
    logic              load;
    logic              cordic_step;
    logic [STEP_W-1:0] step;
    logic              mul;
    logic              apply_obj;
    logic              eval;
    logic              div_step;
    logic              hist_rd;
    logic              hist_wr;
    logic [SEL_W-1:0]  hist_sel;
    logic              read_rd;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic       last;
    logic       veto;
    logic       out_busy;
  } stat_t;

  function automatic logic [ZW-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [ZW-1:0] r;
    unique case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2F9;
      5'd15:   r = 32'h0000517C;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A2F;
      5'd19:   r = 32'h00000517;
      5'd20:   r = 32'h0000028B;
      5'd21:   r = 32'h00000145;
      5'd22:   r = 32'h000000A2;
      5'd23:   r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/msel_if.sv */
// Stream interfaces for the event selector: object items in, results out.
// Depends on msel_pkg.
interface msel_in_if;
  import msel_pkg::*;
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic [PT_W-1:0]     px;
  logic [PT_W-1:0]     py;
  logic [PT_W-1:0]     met_value;
  logic [ANG_W-1:0]    met_angle;
  logic [SEL_W-1:0]    hist_select;
  logic [BIN_W-1:0]    bin_index;
  logic                last_in_event;
  modport source (output valid, mode, px, py, met_value, met_angle, hist_select,
                  bin_index, last_in_event, input ready);
  modport sink (input valid, mode, px, py, met_value, met_angle, hist_select,
                bin_index, last_in_event, output ready);
endinterface

interface msel_out_if;
  import msel_pkg::*;
  logic                valid;
  logic                ready;
  logic                result_kind;
  logic                veto_passed;
  logic [PT_W-1:0]     leading_jet_pt;
  logic [PT_W-1:0]     missing_et;
  logic [ANG_W-1:0]    min_jet_met_gap;
  logic                in_signal_region;
  logic [OUT_W-1:0]    bin_count;
  logic [OUT_W-1:0]    total_count;
  logic [OUT_W-1:0]    veto_count;
  logic [OUT_W-1:0]    gap_count;
  logic [OUT_W-1:0]    veto_gap_count;
  modport source (output valid, result_kind, veto_passed, leading_jet_pt, missing_et,
                  min_jet_met_gap, in_signal_region, bin_count, total_count, veto_count,
                  gap_count, veto_gap_count, input ready);
  modport sink (input valid, result_kind, veto_passed, leading_jet_pt, missing_et,
                min_jet_met_gap, in_signal_region, bin_count, total_count, veto_count,
                gap_count, veto_gap_count, output ready);
endinterface

/* rtl/met_jet_event_selector.sv */
// Top level of the MET and jet event selector.
// Joins msel_ctrl and msel_datapath to the stream interfaces. Uses msel_pkg, msel_if.
//
//   channel  | direction | payload
//   items    | in        | mode, px, py, met_value, met_angle, hist_select,
//            |           | bin_index, last_in_event
//   results  | out       | summary or bin read, four region counters
//   cfg      | in        | cfg_wr_en, cfg_index, cfg_data (write only)
//
// Lepton or jet: 16 CORDIC iterations, one gain multiply, one update.
// MET item: one update. Histogram read: one RAM read, then the emit. Event end adds
// evaluation, the shared-divisor bin dividers, histogram read-modify-write through
// the single RAM port, and the emit.
// Reset clears control, counters and the histogram valid bits.
// A pending result is held in the output register; a stalled result blocks
// only the next emit.
module met_jet_event_selector (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [msel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [msel_pkg::CFG_W-1:0]     cfg_data,
  msel_in_if.sink                        items,
  msel_out_if.source                     results
);
  import msel_pkg::*;

  cmd_t      cmd;
  stat_t     st;
  in_item_t  in_item;
  out_item_t out_item;
  logic      in_ready;

  assign items.ready = in_ready;
  assign in_item = '{mode: items.mode, px: items.px, py: items.py,
                     met_value: items.met_value, met_angle: items.met_angle,
                     hist_select: items.hist_select, bin_index: items.bin_index,
                     last_in_event: items.last_in_event};

  msel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_mode  (items.mode),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  msel_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .out_item  (out_item)
  );

  assign results.result_kind      = out_item.result_kind;
  assign results.veto_passed      = out_item.veto_passed;
  assign results.leading_jet_pt   = out_item.leading_jet_pt;
  assign results.missing_et       = out_item.missing_et;
  assign results.min_jet_met_gap  = out_item.min_jet_met_gap;
  assign results.in_signal_region = out_item.in_signal_region;
  assign results.bin_count        = out_item.bin_count;
  assign results.total_count      = out_item.total_count;
  assign results.veto_count       = out_item.veto_count;
  assign results.gap_count        = out_item.gap_count;
  assign results.veto_gap_count   = out_item.veto_gap_count;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.mode <= MODE_READ) |=> !items.ready)
    else $error("block took a transaction while busy");

  a_reset_no_result: assert property (@(posedge clk)
    rst |=> !results.valid)
    else $error("result present after reset");

  a_summary_bin_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.result_kind == KIND_SUMMARY) |-> results.bin_count == '0)
    else $error("summary carries a bin count");

  a_read_no_event: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.result_kind == KIND_READ)
      |-> (!results.veto_passed && !results.in_signal_region && results.missing_et == '0))
    else $error("bin read carries event fields");
endmodule

/* rtl/msel_ram.sv */
// Generic single-port-address RAM with registered read and read enable.
// No dependencies.
module msel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 104
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

/* rtl/msel_ctrl.sv */
// Controller state machine for the event selector.
// Sequences CORDIC, event evaluation, bin division and histogram updates. Uses msel_pkg.
module msel_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2:0]      in_mode,
  output logic            in_ready,
  input  msel_pkg::stat_t st,
  output msel_pkg::cmd_t  cmd
);
  import msel_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CORDIC = 10'b00_0000_0010,
    S_MUL    = 10'b00_0000_0100,
    S_OBJ    = 10'b00_0000_1000,
    S_EVAL   = 10'b00_0001_0000,
    S_DIV    = 10'b00_0010_0000,
    S_HRD    = 10'b00_0100_0000,
    S_HWR    = 10'b00_1000_0000,
    S_RRD    = 10'b01_0000_0000,
    S_EMIT   = 10'b10_0000_0000
  } state_t;

  state_t             state, state_next;
  logic [STEP_W-1:0]  step, step_next;
  logic [DSTEP_W-1:0] dstep, dstep_next;
  logic [SEL_W-1:0]   hsel, hsel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      dstep <= '0;
      hsel  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      dstep <= dstep_next;
      hsel  <= hsel_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    dstep_next = dstep;
    hsel_next  = hsel;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.step     = step;
    cmd.hist_sel = hsel;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid;
        step_next = '0;
        if (in_valid) begin
          priority case (in_mode)
            MODE_ELECTRON, MODE_MUON, MODE_JET: state_next = S_CORDIC;
            MODE_MET:                           state_next = S_OBJ;
            MODE_READ:                          state_next = S_RRD;
            default:                            state_next = S_IDLE;
          endcase
        end
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        step_next = step + 1'b1;
        if (step == STEP_W'(CORDIC_STEPS - 1)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_OBJ;
      end
      S_OBJ: begin
        cmd.apply_obj = 1'b1;
        state_next = st.last ? S_EVAL : S_IDLE;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        dstep_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dstep_next = dstep + 1'b1;
        if (dstep == DSTEP_W'(DIV_STEPS - 1)) begin
          hsel_next  = st.veto ? SEL_W'(0) : SEL_W'(2);
          state_next = S_HRD;
        end
      end
      S_HRD: begin
        cmd.hist_rd = 1'b1;
        state_next  = S_HWR;
      end
      S_HWR: begin
        cmd.hist_wr = 1'b1;
        if (hsel == SEL_W'(HIST_SETS - 1)) begin
          state_next = S_EMIT;
        end else begin
          hsel_next  = hsel + 1'b1;
          state_next = S_HRD;
        end
      end
      S_RRD: begin
        cmd.read_rd = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/msel_datapath.sv */
// Datapath of the event selector: CORDIC, event state, counters, bin divider,
// histogram store and output register. Uses msel_pkg and msel_ram.
module msel_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [msel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [msel_pkg::CFG_W-1:0]  cfg_data,
  input  msel_pkg::in_item_t          in_item,
  input  msel_pkg::cmd_t              cmd,
  output msel_pkg::stat_t             st,
  input  logic                        out_ready,
  output logic                        out_valid,
  output msel_pkg::out_item_t         out_item
);
  import msel_pkg::*;

  logic [PT_W-1:0]  lepton_pt_cut, jet_gap_pt_cut, met_cut, leading_jet_cut;
  logic [ANG_W-1:0] gap_angle_cut;
  logic [BW_W-1:0]  bin_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      lepton_pt_cut   <= PT_W'(80);
      jet_gap_pt_cut  <= PT_W'(800);
      met_cut         <= PT_W'(32000);
      leading_jet_cut <= PT_W'(8000);
      gap_angle_cut   <= ANG_W'(5215);
      bin_width       <= BW_W'(1600);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LEPTON_PT:   lepton_pt_cut   <= cfg_data;
        CFG_JET_GAP_PT:  jet_gap_pt_cut  <= cfg_data;
        CFG_MET:         met_cut         <= cfg_data;
        CFG_LEADING_JET: leading_jet_cut <= cfg_data;
        CFG_GAP_ANGLE:   gap_angle_cut   <= cfg_data[ANG_W-1:0];
        CFG_BIN_WIDTH:   bin_width       <= cfg_data[BW_W-1:0];
        default: ;
      endcase
    end
  end

  in_item_t item;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
    end
  end

  // CORDIC vectoring
  logic signed [CW-1:0] cx, cy, x0, y0, dx, dy;
  logic [ZW-1:0]        cz, zr;
  logic                 zero_vec;
  logic [63:0]          prod, prod_r;
  logic [21:0]          mag_w;
  logic [PT_W-1:0]      pt;
  logic [ANG_W-1:0]     ang;

  assign x0 = {{(CW-PT_W-10){in_item.px[PT_W-1]}}, in_item.px, 10'b0};
  assign y0 = {{(CW-PT_W-10){in_item.py[PT_W-1]}}, in_item.py, 10'b0};
  assign dx = cy >>> cmd.step;
  assign dy = cx >>> cmd.step;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zero_vec <= (in_item.px == '0) && (in_item.py == '0);
      if (in_item.px[PT_W-1]) begin
        cx <= -x0;
        cy <= -y0;
        cz <= 32'h8000_0000;
      end else begin
        cx <= x0;
        cy <= y0;
        cz <= '0;
      end
    end else if (cmd.cordic_step) begin
      if (!cy[CW-1]) begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + atan_turn(cmd.step);
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - atan_turn(cmd.step);
      end
    end
    if (cmd.mul) begin
      prod_r <= prod;
    end
  end

  assign prod  = 64'(cx[CW-1] ? 32'd0 : cx[31:0]) * 64'(GAIN_Q32);
  assign mag_w = 22'((prod_r + (64'd1 << 41)) >> 42);
  assign zr    = cz + 32'h0000_8000;
  assign pt    = zero_vec ? '0 : ((|mag_w[21:20]) ? {PT_W{1'b1}} : mag_w[PT_W-1:0]);
  assign ang   = zero_vec ? '0 : zr[ZW-1:ZW-ANG_W];

  // event state
  logic             veto_clear, sig;
  logic [PT_W-1:0]  leading_magnitude, event_met;
  logic [ANG_W-1:0] event_met_direction, smallest_gap, d, gap;
  logic [COUNT_WIDTH-1:0] cnt [HIST_SETS];
  logic             clear_ev;

  assign d   = ang - event_met_direction;
  assign gap = d[ANG_W-1] ? (~d + 1'b1) : d;
  assign clear_ev = cmd.emit && (item.mode != MODE_READ);

  always_ff @(posedge clk) begin
    if (rst || clear_ev) begin
      veto_clear          <= 1'b1;
      leading_magnitude   <= '0;
      event_met           <= '0;
      event_met_direction <= '0;
      smallest_gap        <= GAP_RESET;
    end else if (cmd.apply_obj) begin
      if (item.mode == MODE_MET) begin
        event_met           <= item.met_value;
        event_met_direction <= item.met_angle;
      end else if (item.mode == MODE_JET) begin
        if (pt > leading_magnitude) begin
          leading_magnitude <= pt;
        end
        if (pt > jet_gap_pt_cut && gap < smallest_gap) begin
          smallest_gap <= gap;
        end
      end else if (pt > lepton_pt_cut) begin
        veto_clear <= 1'b0;
      end
    end
  end

  logic sig_n, gap_ok;
  logic [HIST_SETS-1:0] bump;
  assign sig_n  = (event_met > met_cut) && (leading_magnitude > leading_jet_cut);
  assign gap_ok = smallest_gap > gap_angle_cut;
  assign bump   = {veto_clear & gap_ok, gap_ok, veto_clear, 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HIST_SETS; k++) cnt[k] <= '0;
    end else if (cmd.eval && sig_n) begin
      for (int k = 0; k < HIST_SETS; k++) begin
        if (bump[k] && !(&cnt[k])) cnt[k] <= cnt[k] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) sig <= sig_n;
  end

  // bin dividers, one bit per cycle
  logic [BW_W-1:0] div_w, rm_m, rm_l;
  logic [PT_W-1:0] q_m, q_l;
  logic [BW_W:0]   sh_m, sh_l;
  logic            ge_m, ge_l;
  logic [BIN_W-1:0] bin_m, bin_l, hist_bin, read_bin;

  assign div_w = (bin_width == '0) ? BW_W'(1) : bin_width;
  assign sh_m  = {rm_m, q_m[PT_W-1]};
  assign sh_l  = {rm_l, q_l[PT_W-1]};
  assign ge_m  = sh_m >= {1'b0, div_w};
  assign ge_l  = sh_l >= {1'b0, div_w};

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rm_m <= '0;
      rm_l <= '0;
      q_m  <= event_met;
      q_l  <= leading_magnitude;
    end else if (cmd.div_step) begin
      rm_m <= ge_m ? BW_W'(sh_m - {1'b0, div_w}) : sh_m[BW_W-1:0];
      rm_l <= ge_l ? BW_W'(sh_l - {1'b0, div_w}) : sh_l[BW_W-1:0];
      q_m  <= {q_m[PT_W-2:0], ge_m};
      q_l  <= {q_l[PT_W-2:0], ge_l};
    end
  end

  assign bin_m = (q_m >= PT_W'(HIST_BINS - 1)) ? BIN_W'(HIST_BINS - 1) : q_m[BIN_W-1:0];
  assign bin_l = (q_l >= PT_W'(HIST_BINS - 1)) ? BIN_W'(HIST_BINS - 1) : q_l[BIN_W-1:0];
  assign hist_bin = cmd.hist_sel[0] ? bin_l : bin_m;
  assign read_bin = (item.bin_index >= BIN_W'(HIST_BINS)) ? BIN_W'(HIST_BINS - 1)
                                                         : item.bin_index;

  // histogram store
  logic [HIST_AW-1:0]     addr;
  logic [COUNT_WIDTH-1:0] rdata, cur, wdata;
  logic [HIST_DEPTH-1:0]  hist_valid;
  logic                   rd_valid, re;

  assign re   = cmd.hist_rd || cmd.read_rd;
  assign addr = cmd.read_rd
              ? HIST_AW'(HIST_AW'(item.hist_select) * HIST_AW'(HIST_BINS) + HIST_AW'(read_bin))
              : HIST_AW'(HIST_AW'(cmd.hist_sel) * HIST_AW'(HIST_BINS) + HIST_AW'(hist_bin));
  assign cur   = rd_valid ? rdata : '0;
  assign wdata = (&cur) ? cur : cur + 1'b1;

  msel_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (cmd.hist_wr),
    .re    (re),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (cmd.hist_wr) begin
      hist_valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) rd_valid <= hist_valid[addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.total_count    <= OUT_W'(cnt[0]);
      out_item.veto_count     <= OUT_W'(cnt[1]);
      out_item.gap_count      <= OUT_W'(cnt[2]);
      out_item.veto_gap_count <= OUT_W'(cnt[3]);
      if (item.mode == MODE_READ) begin
        out_item.result_kind      <= KIND_READ;
        out_item.veto_passed      <= 1'b0;
        out_item.leading_jet_pt   <= '0;
        out_item.missing_et       <= '0;
        out_item.min_jet_met_gap  <= '0;
        out_item.in_signal_region <= 1'b0;
        out_item.bin_count        <= OUT_W'(cur);
      end else begin
        out_item.result_kind      <= KIND_SUMMARY;
        out_item.veto_passed      <= veto_clear;
        out_item.leading_jet_pt   <= leading_magnitude;
        out_item.missing_et       <= event_met;
        out_item.min_jet_met_gap  <= smallest_gap;
        out_item.in_signal_region <= sig;
        out_item.bin_count        <= '0;
      end
    end
  end

  assign st.last     = item.last_in_event;
  assign st.veto     = veto_clear;
  assign st.out_busy = out_valid && !out_ready;
endmodule
